// ----- rtl/core/sdcf_pkg.sv -----
// Shared types, constants, frame tables and CRC step of the servo drive command framer.
package sdcf_pkg;

   localparam int MODE_W     = 2;
   localparam int VEL_W      = 24;
   localparam int BYTE_W     = 8;
   localparam int SCALED_W   = 32;
   localparam int PROD_W     = 32;
   localparam int QUOT_W     = 29;
   localparam int RECIP_W    = 32;
   localparam int CRC_W      = 16;
   localparam int IDX_W      = 4;
   localparam int MUL_W      = PROD_W + RECIP_W;

   localparam logic [PROD_W-1:0]  VEL_SCALE   = PROD_W'(437);
   localparam logic [PROD_W-1:0]  VEL_ROUND   = PROD_W'(5);
   localparam logic [RECIP_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int                 DIV10_SHIFT = 35;

   localparam logic [CRC_W-1:0] XMODEM_GEN = 16'h1021;
   localparam logic [CRC_W-1:0] CRC_INIT   = 16'h0000;

   localparam logic [IDX_W-1:0] HDR_LAST_IDX = 4'd7;
   localparam logic [IDX_W-1:0] DATA_B0_IDX  = 4'd8;
   localparam logic [IDX_W-1:0] DATA_B1_IDX  = 4'd9;
   localparam logic [IDX_W-1:0] DATA_B2_IDX  = 4'd10;
   localparam logic [IDX_W-1:0] DATA_B3_IDX  = 4'd11;
   localparam logic [IDX_W-1:0] CRC_HI_IDX   = 4'd12;
   localparam logic [IDX_W-1:0] LAST_VEL_IDX = 4'd13;
   localparam logic [IDX_W-1:0] LAST_FIX_IDX = 4'd11;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_VEL          = 2'd0,
      MODE_WRITE_ACCESS = 2'd1,
      MODE_BRIDGE_EN    = 2'd2,
      MODE_BRIDGE_DIS   = 2'd3
   } mode_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_SEND = 1'b1
   } back_state_type;

   typedef struct packed {
      mode_type            mode;
      logic                side;
      logic [SCALED_W-1:0] scaled;
   } cmd_type;

   localparam logic [BYTE_W-1:0] VEL_HDR [0:1][0:7] = '{
      '{8'hA5, 8'h3E, 8'h02, 8'h45, 8'h00, 8'h02, 8'h5A, 8'h18},
      '{8'hA5, 8'h3F, 8'h02, 8'h45, 8'h02, 8'h02, 8'h96, 8'h2B}
   };

   localparam logic [BYTE_W-1:0] FIX_FRAME [0:1][1:3][0:11] = '{
      '{
         '{8'hA5, 8'h3E, 8'h02, 8'h07, 8'h00, 8'h01, 8'h19, 8'hB6, 8'hFF, 8'h00, 8'h03, 8'hFF},
         '{8'hA5, 8'h3E, 8'h02, 8'h01, 8'h00, 8'h01, 8'hAB, 8'h16, 8'h00, 8'h00, 8'h00, 8'h00},
         '{8'hA5, 8'h3E, 8'h02, 8'h01, 8'h00, 8'h01, 8'hAB, 8'h16, 8'h01, 8'h00, 8'h33, 8'h31}
      },
      '{
         '{8'hA5, 8'h3F, 8'h02, 8'h07, 8'h00, 8'h01, 8'hB3, 8'hE7, 8'hFF, 8'h00, 8'h03, 8'hFF},
         '{8'hA5, 8'h3F, 8'h02, 8'h01, 8'h00, 8'h01, 8'h01, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},
         '{8'hA5, 8'h3F, 8'h02, 8'h01, 8'h00, 8'h01, 8'h01, 8'h47, 8'h01, 8'h00, 8'h33, 8'h31}
      }
   };

   function automatic logic [CRC_W-1:0] crc16_byte_f(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ XMODEM_GEN;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [BYTE_W-1:0] frame_byte_f(input cmd_type cmd,
                                                      input logic [IDX_W-1:0] idx,
                                                      input logic [CRC_W-1:0] crc);
      logic [BYTE_W-1:0] b;
      b = '0;
      if (cmd.mode == MODE_VEL) begin
         if (idx <= HDR_LAST_IDX) begin
            b = VEL_HDR[cmd.side][idx[2:0]];
         end else begin
            unique case (idx)
               DATA_B0_IDX: b = cmd.scaled[7:0];
               DATA_B1_IDX: b = cmd.scaled[15:8];
               DATA_B2_IDX: b = cmd.scaled[23:16];
               DATA_B3_IDX: b = cmd.scaled[31:24];
               CRC_HI_IDX:  b = crc[15:8];
               default:     b = crc[7:0];
            endcase
         end
      end else begin
         b = FIX_FRAME[cmd.side][cmd.mode][idx];
      end
      return b;
   endfunction

endpackage

// ----- rtl/core/sdcf_if.sv -----
// Command and byte stream channel interfaces of the servo drive command framer.
interface sdcf_req_if;
   import sdcf_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [MODE_W-1:0]       mode;
   logic                    motor_side;
   logic signed [VEL_W-1:0] velocity_request;

   modport source (output valid, mode, motor_side, velocity_request, input ready);
   modport sink   (input valid, mode, motor_side, velocity_request, output ready);
endinterface

interface sdcf_rsp_if;
   import sdcf_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic              last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

// ----- rtl/core/sdcf_front.sv -----
// Command intake: classifies the command and scales the velocity in a three stage pipe.
module sdcf_front (
   input  logic             clock,
   input  logic             reset,
   sdcf_req_if.sink         req_bus,
   output sdcf_pkg::cmd_type push_cmd,
   output logic             push_valid,
   input  logic             push_ready
);
   import sdcf_pkg::*;

   logic                advance;
   logic [VEL_W-1:0]    vel_bits;
   logic                vel_neg;
   logic [VEL_W-1:0]    vel_mag;
   logic [MUL_W-1:0]    recip_prod;

   logic                valid1_ff, valid1_in;
   mode_type            mode1_ff;
   logic                side1_ff;
   logic                neg1_ff;
   logic [VEL_W-1:0]    mag1_ff;

   logic                valid2_ff, valid2_in;
   mode_type            mode2_ff;
   logic                side2_ff;
   logic                neg2_ff;
   logic [PROD_W-1:0]   prod2_ff, prod2_in;

   logic                valid3_ff, valid3_in;
   mode_type            mode3_ff;
   logic                side3_ff;
   logic                neg3_ff;
   logic [QUOT_W-1:0]   quot3_ff, quot3_in;

   assign advance       = !valid3_ff || push_ready;
   assign req_bus.ready = advance;

   assign vel_bits = req_bus.velocity_request;
   assign vel_neg  = vel_bits[VEL_W-1];
   assign vel_mag  = vel_neg ? (~vel_bits + VEL_W'(1)) : vel_bits;

   assign valid1_in = req_bus.valid;
   assign valid2_in = valid1_ff;
   assign valid3_in = valid2_ff;

   assign prod2_in   = PROD_W'(mag1_ff) * VEL_SCALE + VEL_ROUND;
   assign recip_prod = MUL_W'(prod2_ff) * MUL_W'(DIV10_RECIP);
   assign quot3_in   = recip_prod[DIV10_SHIFT +: QUOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode1_ff <= mode_type'(req_bus.mode);
         side1_ff <= req_bus.motor_side;
         neg1_ff  <= vel_neg;
         mag1_ff  <= vel_mag;
         mode2_ff <= mode1_ff;
         side2_ff <= side1_ff;
         neg2_ff  <= neg1_ff;
         prod2_ff <= prod2_in;
         mode3_ff <= mode2_ff;
         side3_ff <= side2_ff;
         neg3_ff  <= neg2_ff;
         quot3_ff <= quot3_in;
      end
   end

   assign push_valid      = valid3_ff;
   assign push_cmd.mode   = mode3_ff;
   assign push_cmd.side   = side3_ff;
   assign push_cmd.scaled = neg3_ff ? (SCALED_W'(0) - SCALED_W'(quot3_ff))
                                    : SCALED_W'(quot3_ff);

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid3_ff && !push_ready) |=> (valid3_ff && $stable(quot3_ff) && $stable(neg3_ff)))
      else $error("front output changed while stalled");
   a_take_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> valid1_ff)
      else $error("accepted command lost in first stage");
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (valid2_ff && advance) |=> valid3_ff)
      else $error("second stage did not advance");
`endif

endmodule

// ----- rtl/core/sdcf_cmd_queue.sv -----
// Short command queue between the intake pipe and the byte serializer.
module sdcf_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  sdcf_pkg::cmd_type push_cmd,
   input  logic              push_valid,
   output logic              push_ready,
   output sdcf_pkg::cmd_type pop_cmd,
   output logic              pop_valid,
   input  logic              pop_ready
);
   import sdcf_pkg::*;

   cmd_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");
   a_push_only: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree when empty");
`endif

endmodule

// ----- rtl/core/sdcf_back.sv -----
// Byte serializer: walks each queued command frame, folds the CRC, and drives the output register.
module sdcf_back (
   input  logic              clock,
   input  logic              reset,
   input  sdcf_pkg::cmd_type pop_cmd,
   input  logic              pop_valid,
   output logic              pop_ready,
   sdcf_rsp_if.source        rsp_bus
);
   import sdcf_pkg::*;

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [CRC_W-1:0]   crc_ff;
   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  rsp_byte_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               cur_last;
   logic [BYTE_W-1:0]  cur_byte;
   logic               emit;
   logic               load;
   logic               in_data;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign cur_last = (cmd_ff.mode == MODE_VEL) ? (idx_ff == LAST_VEL_IDX)
                                               : (idx_ff == LAST_FIX_IDX);
   assign cur_byte = frame_byte_f(cmd_ff, idx_ff, crc_ff);
   assign in_data  = (cmd_ff.mode == MODE_VEL) && (idx_ff >= DATA_B0_IDX)
                     && (idx_ff <= DATA_B3_IDX);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               state_in = BACK_SEND;
            end
         end
         BACK_SEND: begin
            if (out_free && cur_last && !pop_valid) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      emit      = 1'b0;
      pop_ready = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
         end
         BACK_SEND: begin
            emit      = out_free;
            pop_ready = out_free && cur_last;
         end
         default: begin
            emit      = 1'b0;
            pop_ready = 1'b0;
         end
      endcase
   end

   assign load = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= pop_cmd;
         idx_ff <= '0;
         crc_ff <= CRC_INIT;
      end else if (emit) begin
         idx_ff <= idx_ff + 1'b1;
         if (in_data) begin
            crc_ff <= crc16_byte_f(crc_ff, cur_byte);
         end
      end
      if (emit) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= cur_last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.frame_byte = rsp_byte_ff;
   assign rsp_bus.last_byte  = rsp_last_ff;

`ifndef SYNTHESIS
   a_fix_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_SEND && cmd_ff.mode != MODE_VEL) |-> (idx_ff <= LAST_FIX_IDX))
      else $error("fixed frame index overrun");
   a_vel_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_SEND) |-> (idx_ff <= LAST_VEL_IDX))
      else $error("velocity frame index overrun");
   a_chain_frames: assert property (@(posedge clock) disable iff (reset)
      (emit && cur_last && pop_valid) |=> (state_ff == BACK_SEND && idx_ff == '0))
      else $error("next frame not started after last beat");
   a_last_pops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff && rsp_bus.ready) |-> (state_ff == BACK_IDLE || idx_ff == '0
                                                          || emit))
      else $error("serializer stuck after last beat");
`endif

endmodule

// ----- rtl/core/servo_drive_command_framer_core.sv -----
// Top level of the servo drive command framer.
// Each accepted command becomes one drive frame streamed one byte per beat, with last_byte on
// the final beat: a velocity command (mode 0) gives 14 bytes (header, velocity scaled by 43.7
// as four little-endian bytes, CRC-16/XMODEM of those bytes high byte first), and modes 1 to 3
// give fixed 12-byte frames. The byte serializer sends one byte per cycle while the output is
// ready; frames follow each other with no gap when the next command is already queued. On an
// idle block the first byte passes the intake pipe stages, the queue slot, the serializer's
// command register and its output register before it is valid. A two-entry command queue lets
// new commands be taken while a frame is still streaming.
module servo_drive_command_framer_core (
   input  logic     clock,
   input  logic     reset,
   sdcf_req_if.sink   req_bus,
   sdcf_rsp_if.source rsp_bus
);
   import sdcf_pkg::*;

   cmd_type push_cmd;
   logic    push_valid;
   logic    push_ready;
   cmd_type pop_cmd;
   logic    pop_valid;
   logic    pop_ready;

   sdcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   sdcf_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   sdcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_cmd   (pop_cmd),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- sim/sdcf_frame_checker.sv -----
// Checker for the servo drive command framer: predicts each frame and compares its byte stream.
module sdcf_frame_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [sdcf_pkg::MODE_W-1:0] req_mode,
   input  logic                        req_motor_side,
   input  logic [sdcf_pkg::VEL_W-1:0]  req_velocity_request,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [sdcf_pkg::BYTE_W-1:0] rsp_frame_byte,
   input  logic                        rsp_last_byte,
   output int                          mismatch_count,
   output int                          bytes_outstanding
);
   import sdcf_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_beat_type;

   localparam logic [7:0] DRIVE_HEADER [0:1][0:7] = '{
      '{8'hA5, 8'h3E, 8'h02, 8'h45, 8'h00, 8'h02, 8'h5A, 8'h18},
      '{8'hA5, 8'h3F, 8'h02, 8'h45, 8'h02, 8'h02, 8'h96, 8'h2B}
   };

   localparam logic [7:0] FIXED_FRAME_BYTES [0:1][0:2][0:11] = '{
      '{
         '{8'hA5, 8'h3E, 8'h02, 8'h07, 8'h00, 8'h01, 8'h19, 8'hB6, 8'hFF, 8'h00, 8'h03, 8'hFF},
         '{8'hA5, 8'h3E, 8'h02, 8'h01, 8'h00, 8'h01, 8'hAB, 8'h16, 8'h00, 8'h00, 8'h00, 8'h00},
         '{8'hA5, 8'h3E, 8'h02, 8'h01, 8'h00, 8'h01, 8'hAB, 8'h16, 8'h01, 8'h00, 8'h33, 8'h31}
      },
      '{
         '{8'hA5, 8'h3F, 8'h02, 8'h07, 8'h00, 8'h01, 8'hB3, 8'hE7, 8'hFF, 8'h00, 8'h03, 8'hFF},
         '{8'hA5, 8'h3F, 8'h02, 8'h01, 8'h00, 8'h01, 8'h01, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},
         '{8'hA5, 8'h3F, 8'h02, 8'h01, 8'h00, 8'h01, 8'h01, 8'h47, 8'h01, 8'h00, 8'h33, 8'h31}
      }
   };

   frame_beat_type frame_bytes_due[$];

   function automatic logic [15:0] xmodem_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      logic        feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[15] ^ data[i];
         acc = {acc[14:0], 1'b0} ^ (feedback ? 16'h1021 : 16'h0000);
      end
      return acc;
   endfunction

   // Multiply by 43.7 with round half away from zero.
   function automatic logic [31:0] scale_velocity_counts(input logic [23:0] raw);
      logic [24:0] magnitude;
      logic [63:0] product;
      logic [31:0] rounded;
      magnitude = raw[23] ? (25'd0 - {raw[23], raw}) : {1'b0, raw};
      product   = 64'(magnitude) * 64'd437 + 64'd5;
      rounded   = 32'(product / 64'd10);
      return raw[23] ? (32'd0 - rounded) : rounded;
   endfunction

   function automatic void predict_frame(input mode_type mode, input logic side,
                                         input logic [23:0] raw);
      logic [7:0]  frame [0:13];
      logic [31:0] scaled;
      logic [15:0] crc;
      int          len;
      if (mode == MODE_VEL) begin
         scaled = scale_velocity_counts(raw);
         crc    = 16'h0000;
         for (int k = 0; k < 8; k++) begin
            frame[k] = DRIVE_HEADER[side][k];
         end
         for (int k = 0; k < 4; k++) begin
            frame[8 + k] = scaled[8 * k +: 8];
            crc = xmodem_update(crc, frame[8 + k]);
         end
         frame[12] = crc[15:8];
         frame[13] = crc[7:0];
         len = 14;
      end else begin
         for (int k = 0; k < 12; k++) begin
            frame[k] = FIXED_FRAME_BYTES[side][int'(mode) - 1][k];
         end
         len = 12;
      end
      for (int k = 0; k < len; k++) begin
         frame_bytes_due.push_back('{data: frame[k], last: (k == len - 1)});
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("%0t: frame mismatch on %s: got %02h, want %02h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      frame_beat_type want;
      if (reset) begin
         frame_bytes_due.delete();
         mismatch_count = 0;
         bytes_outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_bytes_due.size() == 0) begin
               report_mismatch("unexpected beat", rsp_frame_byte, 8'h00);
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_frame_byte !== want.data) begin
                  report_mismatch("frame_byte", rsp_frame_byte, want.data);
               end
               if (rsp_last_byte !== want.last) begin
                  report_mismatch("last_byte", 8'(rsp_last_byte), 8'(want.last));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_frame(mode_type'(req_mode), req_motor_side, req_velocity_request);
         end
         bytes_outstanding <= frame_bytes_due.size();
      end
   end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the servo drive command framer: clock, reset, stimulus and verdict.
module tb;
   import sdcf_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_COMMANDS = 480;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   bytes_outstanding;
   int   quiet_cycles;
   int   rsp_hold;
   bit   cmd_steady;
   bit   rsp_steady;

   sdcf_req_if req_bus ();
   sdcf_rsp_if rsp_bus ();

   servo_drive_command_framer_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sdcf_frame_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_bus.valid),
      .req_ready            (req_bus.ready),
      .req_mode             (req_bus.mode),
      .req_motor_side       (req_bus.motor_side),
      .req_velocity_request (req_bus.velocity_request),
      .rsp_valid            (rsp_bus.valid),
      .rsp_ready            (rsp_bus.ready),
      .rsp_frame_byte       (rsp_bus.frame_byte),
      .rsp_last_byte        (rsp_bus.last_byte),
      .mismatch_count       (mismatch_count),
      .bytes_outstanding    (bytes_outstanding)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_hold = rsp_steady ? 0 : $urandom_range(0, 7);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_bus.ready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_command(input mode_type mode, input logic side, input logic [VEL_W-1:0] vel);
      int unsigned gap;
      gap = cmd_steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.mode             <= mode;
      req_bus.motor_side       <= side;
      req_bus.velocity_request <= vel;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Hold the command side until every predicted byte has come back.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (bytes_outstanding != 0) @(posedge clock);
   endtask

   initial begin
      logic [VEL_W-1:0] corner_vel [13];
      logic [VEL_W-1:0] vel;
      mode_type         mode;
      corner_vel = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h000005, 24'hFFFFFB, 24'h7FFFFF,
                     24'h800000, 24'h00000A, 24'hFFFFF6, 24'h555555, 24'hAAAAAA, 24'h000003,
                     24'h0FFFFF};
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.mode             = '0;
      req_bus.motor_side       = 1'b0;
      req_bus.velocity_request = '0;
      cmd_steady               = 1'b0;
      rsp_steady               = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 13; k++) begin
         send_command(MODE_VEL, k[0], corner_vel[k]);
      end
      for (int s = 0; s < 2; s++) begin
         send_command(MODE_WRITE_ACCESS, s[0], 24'h800000);
         send_command(MODE_BRIDGE_EN, s[0], 24'h7FFFFF);
         send_command(MODE_BRIDGE_DIS, s[0], 24'($urandom));
      end
      wait_for_drain();

      for (int i = 0; i < RANDOM_COMMANDS; i++) begin
         if (i % 40 == 0) begin
            cmd_steady <= ($urandom_range(0, 3) == 0);
            rsp_steady <= ($urandom_range(0, 3) == 0);
         end
         if (i != 0 && i % 150 == 0) begin
            wait_for_drain();
         end
         mode = ($urandom_range(0, 1) == 0) ? MODE_VEL : mode_type'($urandom_range(1, 3));
         vel = 24'($urandom);
         if ($urandom_range(0, 3) == 0) begin
            vel = 24'($urandom_range(0, 40)) - 24'd20;
         end
         send_command(mode, 1'($urandom_range(0, 1)), vel);
      end

      wait_for_drain();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
